// File: hdl/asfp_pkg.sv
package asfp_pkg;

  // value slots per frame; the index saturates at the last one
  localparam int unsigned MAX_VALUES = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_VALUES);

  // last slot as the four bits shown on the result port
  localparam logic [IDX_W+3:0] LAST_SLOT_EXT = (IDX_W+4)'(MAX_VALUES - 1);
  localparam logic [3:0]       LAST_SLOT4    = LAST_SLOT_EXT[3:0];

  // magnitude clamp, 2^31
  localparam logic [31:0] LIMIT_MAG = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [7:0] RST_START_CHAR = 8'd91;
  localparam logic [7:0] RST_END_CHAR   = 8'd93;
  localparam logic [7:0] RST_SEP_CHAR   = 8'd44;
  localparam logic [7:0] RST_US_TAG     = 8'd117;
  localparam logic [7:0] RST_IR_TAG     = 8'd105;

  typedef enum logic [2:0] {
    REG_START_CHAR = 3'd0,
    REG_END_CHAR   = 3'd1,
    REG_SEP_CHAR   = 3'd2,
    REG_US_TAG     = 3'd3,
    REG_IR_TAG     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               sensor_kind;
    logic [3:0]         value_index;
    logic signed [31:0] reading;
    logic               frame_end;
    logic               too_many;
  } result_t;

endpackage

// File: hdl/ascii_sensor_frame_parser_top.sv
// ascii sensor frame parser: takes one received byte per item and looks for
// frames "start kind field sep field ... end" (by default "[u 12,-3, +7]").
// the kind byte picks ultrasonic (kind 0) or infrared (kind 1); any other kind
// byte drops the frame up to the end byte, an end byte right after start gives
// an empty frame with no result. each field gives the signed decimal number at
// its head (leading spaces skipped, optional sign, stops at the first
// non-digit, no digits gives 0, overflow clamps to the 32-bit limits). one
// result item leaves per separator or end byte, tagged with kind, slot index
// and frame_end on the last value; past the last slot the index sticks and
// too_many is set. the user must set the framing bytes and tags through the
// cfg port only while idle; the block does not enforce it. throughput is one
// byte per clock while in_ready is high: the whole byte update, a multiply
// by ten as two shifts and an add, sits between the state registers and the
// result register. results go through an output register backed by one skid
// entry, so in_ready only drops when both hold a result not yet taken.
module ascii_sensor_frame_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_sensor_kind,
  output logic [3:0]         out_value_index,
  output logic signed [31:0] out_reading,
  output logic               out_frame_end,
  output logic               out_too_many
);
  import asfp_pkg::*;

  typedef enum logic [1:0] {
    FR_HUNT    = 2'd0,
    FR_KIND    = 2'd1,
    FR_FIELDS  = 2'd2,
    FR_DISCARD = 2'd3
  } frame_phase_t;

  typedef enum logic [1:0] {
    FLD_LEAD   = 2'd0,
    FLD_SIGN   = 2'd1,
    FLD_DIGITS = 2'd2,
    FLD_DONE   = 2'd3
  } field_phase_t;

  // configuration
  logic [7:0] start_char_r, end_char_r, sep_char_r, us_tag_r, ir_tag_r;

  // parser state
  frame_phase_t     frame_r, frame_nxt;
  field_phase_t     field_r, field_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      acc_r, acc_nxt;       // magnitude, clamped at 2^31
  logic             sat_r, sat_nxt;
  logic             kind_r, kind_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;

  // output register and skid entry
  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  logic              accept;
  logic [7:0]        b;
  logic              emit, emit_last;
  result_t           res;
  logic              is_space, is_digit;
  logic [35:0]       acc_next_wide;
  logic [IDX_W+3:0]  idx_ext;
  logic              out_take;

  assign in_ready = !skid_vld_r;
  assign accept   = in_valid && in_ready;
  assign b        = in_rx_byte;
  assign out_take = out_vld_r && out_ready;

  assign is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // acc*10 + digit; digit is the low nibble for '0'..'9'
  assign acc_next_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                       + {32'd0, b[3:0]};

  assign idx_ext = {4'd0, idx_r};

  // value of the field as it stands
  always_comb begin
    res.sensor_kind = kind_r;
    res.value_index = idx_ext[3:0];
    res.frame_end   = emit_last;
    res.too_many    = ovf_r;
    if (neg_r) begin
      if (sat_r || acc_r >= LIMIT_MAG) begin
        res.reading = LIMIT_MAG;
      end else begin
        res.reading = 32'd0 - acc_r;
      end
    end else begin
      if (sat_r || acc_r > POS_MAX) begin
        res.reading = POS_MAX;
      end else begin
        res.reading = acc_r;
      end
    end
  end

  // byte update
  always_comb begin
    frame_nxt = frame_r;
    field_nxt = field_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    emit_last = 1'b0;

    if (accept) begin
      case (frame_r)
        FR_HUNT: begin
          if (b == start_char_r) frame_nxt = FR_KIND;
        end
        FR_KIND: begin
          if (b == end_char_r) begin
            frame_nxt = FR_HUNT;
          end else if (b == us_tag_r || b == ir_tag_r) begin
            kind_nxt  = (b != us_tag_r);
            idx_nxt   = '0;
            ovf_nxt   = 1'b0;
            field_nxt = FLD_LEAD;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
            sat_nxt   = 1'b0;
            frame_nxt = FR_FIELDS;
          end else begin
            frame_nxt = FR_DISCARD;
          end
        end
        FR_FIELDS: begin
          if (b == end_char_r) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            field_nxt = FLD_LEAD;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
            sat_nxt   = 1'b0;
            idx_nxt   = '0;
            ovf_nxt   = 1'b0;
            frame_nxt = FR_HUNT;
          end else if (b == sep_char_r) begin
            emit      = 1'b1;
            field_nxt = FLD_LEAD;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
            sat_nxt   = 1'b0;
            if (idx_ext >= LAST_SLOT_EXT) begin
              ovf_nxt = 1'b1;   // stick at the last slot
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end else begin
            case (field_r)
              FLD_LEAD: begin
                if (is_space) begin
                  field_nxt = FLD_LEAD;
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                  neg_nxt   = (b == CH_MINUS);
                  field_nxt = FLD_SIGN;
                end else if (is_digit) begin
                  field_nxt = FLD_DIGITS;
                  if (sat_r || acc_next_wide > {4'd0, LIMIT_MAG}) begin
                    sat_nxt = 1'b1;
                    acc_nxt = LIMIT_MAG;
                  end else begin
                    acc_nxt = acc_next_wide[31:0];
                  end
                end else begin
                  field_nxt = FLD_DONE;
                end
              end
              FLD_SIGN: begin
                if (is_digit) begin
                  field_nxt = FLD_DIGITS;
                  if (sat_r || acc_next_wide > {4'd0, LIMIT_MAG}) begin
                    sat_nxt = 1'b1;
                    acc_nxt = LIMIT_MAG;
                  end else begin
                    acc_nxt = acc_next_wide[31:0];
                  end
                end else begin
                  // a lone sign gives 0
                  field_nxt = FLD_DONE;
                  acc_nxt   = '0;
                  neg_nxt   = 1'b0;
                end
              end
              FLD_DIGITS: begin
                if (is_digit) begin
                  if (sat_r || acc_next_wide > {4'd0, LIMIT_MAG}) begin
                    sat_nxt = 1'b1;
                    acc_nxt = LIMIT_MAG;
                  end else begin
                    acc_nxt = acc_next_wide[31:0];
                  end
                end else begin
                  field_nxt = FLD_DONE;
                end
              end
              default: begin
                field_nxt = field_r;   // rest of the field is ignored
              end
            endcase
          end
        end
        default: begin
          if (b == end_char_r) frame_nxt = FR_HUNT;
        end
      endcase
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      // no item is taken while the skid entry is full
      if (out_take) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (emit) begin
      if (!out_vld_r || out_take) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= RST_START_CHAR;
      end_char_r   <= RST_END_CHAR;
      sep_char_r   <= RST_SEP_CHAR;
      us_tag_r     <= RST_US_TAG;
      ir_tag_r     <= RST_IR_TAG;
      frame_r      <= FR_HUNT;
      field_r      <= FLD_LEAD;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      sat_r        <= 1'b0;
      kind_r       <= 1'b0;
      idx_r        <= '0;
      ovf_r        <= 1'b0;
      out_vld_r    <= 1'b0;
      skid_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_CHAR: start_char_r <= cfg_wdata;
          REG_END_CHAR:   end_char_r   <= cfg_wdata;
          REG_SEP_CHAR:   sep_char_r   <= cfg_wdata;
          REG_US_TAG:     us_tag_r     <= cfg_wdata;
          REG_IR_TAG:     ir_tag_r     <= cfg_wdata;
          default:        ;            // unused indexes are dropped
        endcase
      end
      frame_r    <= frame_nxt;
      field_r    <= field_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      sat_r      <= sat_nxt;
      kind_r     <= kind_nxt;
      idx_r      <= idx_nxt;
      ovf_r      <= ovf_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_sensor_kind = out_r.sensor_kind;
  assign out_value_index = out_r.value_index;
  assign out_reading     = out_r.reading;
  assign out_frame_end   = out_r.frame_end;
  assign out_too_many    = out_r.too_many;

endmodule

// File: hdl/asfp_checker.sv
module asfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_sensor_kind,
  input logic [3:0]         out_value_index,
  input logic signed [31:0] out_reading,
  input logic               out_frame_end,
  input logic               out_too_many
);
  import asfp_pkg::*;

  // input side only stalls when a result is backed up behind the output
  a_ready_low_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // a fresh result needs an item taken the cycle before
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted item");

  // overflowed frames report the last slot
  a_too_many_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_many |-> out_value_index == LAST_SLOT4)
    else $error("too_many set away from the last slot");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reading)
      && $stable(out_value_index) && $stable(out_sensor_kind)
      && $stable(out_frame_end) && $stable(out_too_many))
    else $error("stalled result changed");

endmodule

bind ascii_sensor_frame_parser_top asfp_checker u_asfp_checker (.*);
